// File: hw/rtl/bskt_pkg.sv
// Shared types and constants for the banked sorted key table.
// No dependencies; imported by every module of the block.
`default_nettype none

package bskt_pkg;

   localparam int BANK_CAPACITY_DEFAULT = 63;
   localparam int BANK_COUNT_DEFAULT    = 2;

   localparam int KEY_W        = 32;
   localparam int PAYLOAD_W    = 32;
   localparam int STATUS_W     = 2;
   localparam int BANK_FIELD_W = 1;
   localparam int POSITION_W   = 6;

   localparam int REQ_TDATA_W = KEY_W + PAYLOAD_W;
   localparam int RSP_BITS    = BANK_FIELD_W + POSITION_W + PAYLOAD_W;
   localparam int RSP_TDATA_W = ((RSP_BITS + 7) / 8) * 8;

   // request selector carried in req_tuser
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_DELETE = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE    = 2'd0,
      STATUS_FULL    = 2'd1,
      STATUS_MISSING = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_NARROW,
      ST_CHECK,
      ST_UP,
      ST_DN,
      ST_INSERT,
      ST_REMOVE,
      ST_FULL,
      ST_MISSING
   } ctrl_state_type;

   typedef enum logic [3:0] {
      DP_NOP,
      DP_LOAD,
      DP_NEXT_BANK,
      DP_READ_MID,
      DP_NARROW,
      DP_READ_LO,
      DP_GRAB,
      DP_UP_PRIME,
      DP_UP_STEP,
      DP_DN_STEP,
      DP_INSERT,
      DP_REMOVE,
      DP_FULL,
      DP_MISSING
   } dp_op_type;

   typedef struct packed {
      logic req_insert;
      logic item_insert;
      logic none_free;
      logic search_open;
      logic lo_in_range;
      logic key_match;
      logic up_needed;
      logic up_more;
      logic dn_needed;
      logic dn_more;
      logic last_bank;
      logic out_free;
   } dp_status_type;

endpackage

`default_nettype wire

// File: hw/rtl/bskt_datapath.sv
// Datapath: table memories, fill counters, search bounds and output register.
// Depends on bskt_pkg; driven one operation per cycle by bskt_ctrl.
`default_nettype none

module bskt_datapath #(
   parameter int BANK_CAPACITY = bskt_pkg::BANK_CAPACITY_DEFAULT,
   parameter int BANK_COUNT    = bskt_pkg::BANK_COUNT_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  bskt_pkg::dp_op_type              dp_op,
   output bskt_pkg::dp_status_type          dp_status,
   input  logic [bskt_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic                             req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [bskt_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic [bskt_pkg::STATUS_W-1:0]    rsp_tuser
);
   import bskt_pkg::*;

   localparam int TOTAL  = BANK_COUNT * BANK_CAPACITY;
   localparam int SLOT_W = $clog2(BANK_CAPACITY + 1);
   localparam int BANK_W = (BANK_COUNT > 1) ? $clog2(BANK_COUNT) : 1;
   localparam int ADDR_W = (TOTAL > 1) ? $clog2(TOTAL) : 1;
   localparam int PAD_W  = RSP_TDATA_W - RSP_BITS;

   localparam logic [SLOT_W-1:0] CAP_SLOT  = SLOT_W'(BANK_CAPACITY);
   localparam logic [BANK_W-1:0] LAST_BANK = BANK_W'(BANK_COUNT - 1);

   // table storage, slot i of bank b at b * capacity + i
   logic [KEY_W-1:0]     key_mem [TOTAL];
   logic [PAYLOAD_W-1:0] pay_mem [TOTAL];

   logic [SLOT_W-1:0] bank_fill_ff [BANK_COUNT];

   logic                 op_ff, op_in;
   logic [KEY_W-1:0]     key_ff, key_in;
   logic [PAYLOAD_W-1:0] pay_ff, pay_in;
   logic [BANK_W-1:0]    bank_ff, bank_in;
   logic [SLOT_W-1:0]    lo_ff, lo_in;
   logic [SLOT_W-1:0]    hi_ff, hi_in;
   logic [SLOT_W-1:0]    idx_ff, idx_in;
   logic [SLOT_W-1:0]    fill_cur_ff, fill_cur_in;
   logic [PAYLOAD_W-1:0] removed_ff, removed_in;
   logic [KEY_W-1:0]     key_rd_ff;
   logic [PAYLOAD_W-1:0] pay_rd_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [BANK_FIELD_W-1:0] rsp_bank_ff, rsp_bank_in;
   logic [POSITION_W-1:0] rsp_pos_ff, rsp_pos_in;
   logic [PAYLOAD_W-1:0]  rsp_removed_ff, rsp_removed_in;

   logic                 mem_we, mem_re;
   logic [SLOT_W-1:0]    wr_slot, rd_slot;
   logic [ADDR_W-1:0]    base, mem_wa, mem_ra;
   logic [KEY_W-1:0]     mem_wkey;
   logic [PAYLOAD_W-1:0] mem_wpay;
   logic                 fill_wr;
   logic [SLOT_W-1:0]    fill_wval;

   logic [BANK_W-1:0] best_bank, bank_sel;
   logic [SLOT_W-1:0] fill_sel, mid;
   logic              none_free;

   // least-filled bank that still has room, lowest index on a tie
   always_comb begin
      logic              found;
      logic [SLOT_W-1:0] best_fill;
      found     = 1'b0;
      best_fill = '0;
      best_bank = '0;
      for (int b = 0; b < BANK_COUNT; b++) begin
         if (bank_fill_ff[b] < CAP_SLOT && (!found || bank_fill_ff[b] < best_fill)) begin
            found     = 1'b1;
            best_bank = BANK_W'(b);
            best_fill = bank_fill_ff[b];
         end
      end
      none_free = !found;
   end

   always_comb begin
      priority if (dp_op == DP_LOAD) begin
         bank_sel = (req_tuser == OP_INSERT) ? best_bank : '0;
      end else if (dp_op == DP_NEXT_BANK) begin
         bank_sel = bank_ff + 1'b1;
      end else begin
         bank_sel = bank_ff;
      end
   end

   assign fill_sel = bank_fill_ff[bank_sel];
   assign mid      = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign base     = ADDR_W'(bank_ff) * ADDR_W'(BANK_CAPACITY);
   assign mem_wa   = base + ADDR_W'(wr_slot);
   assign mem_ra   = base + ADDR_W'(rd_slot);

   always_comb begin
      dp_status.req_insert  = (req_tuser == OP_INSERT);
      dp_status.item_insert = (op_ff == OP_INSERT);
      dp_status.none_free   = none_free;
      dp_status.search_open = (lo_ff < hi_ff);
      dp_status.lo_in_range = (lo_ff < fill_cur_ff);
      dp_status.key_match   = (key_rd_ff == key_ff);
      dp_status.up_needed   = (fill_cur_ff > lo_ff);
      dp_status.up_more     = ((SLOT_W + 1)'(idx_ff) > (SLOT_W + 1)'(lo_ff) + 1'b1);
      dp_status.dn_needed   = ((SLOT_W + 1)'(lo_ff) + 1'b1 < (SLOT_W + 1)'(fill_cur_ff));
      dp_status.dn_more     = ((SLOT_W + 1)'(idx_ff) + (SLOT_W + 1)'(2)
                               < (SLOT_W + 1)'(fill_cur_ff));
      dp_status.last_bank   = (bank_ff == LAST_BANK);
      dp_status.out_free    = !rsp_valid_ff || rsp_tready;
   end

   always_comb begin
      op_in          = op_ff;
      key_in         = key_ff;
      pay_in         = pay_ff;
      bank_in        = bank_ff;
      lo_in          = lo_ff;
      hi_in          = hi_ff;
      idx_in         = idx_ff;
      fill_cur_in    = fill_cur_ff;
      removed_in     = removed_ff;
      mem_we         = 1'b0;
      mem_re         = 1'b0;
      wr_slot        = idx_ff;
      rd_slot        = mid;
      mem_wkey       = key_rd_ff;
      mem_wpay       = pay_rd_ff;
      fill_wr        = 1'b0;
      fill_wval      = fill_cur_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_status_in  = rsp_status_ff;
      rsp_bank_in    = rsp_bank_ff;
      rsp_pos_in     = rsp_pos_ff;
      rsp_removed_in = rsp_removed_ff;
      unique case (dp_op)
         DP_NOP: begin
         end
         DP_LOAD: begin
            op_in       = req_tuser;
            key_in      = req_tdata[KEY_W-1:0];
            pay_in      = req_tdata[REQ_TDATA_W-1:KEY_W];
            bank_in     = bank_sel;
            lo_in       = '0;
            hi_in       = fill_sel;
            fill_cur_in = fill_sel;
         end
         DP_NEXT_BANK: begin
            bank_in     = bank_sel;
            lo_in       = '0;
            hi_in       = fill_sel;
            fill_cur_in = fill_sel;
         end
         DP_READ_MID: begin
            mem_re  = 1'b1;
            rd_slot = mid;
         end
         DP_NARROW: begin
            if (key_rd_ff < key_ff) begin
               lo_in = mid + 1'b1;
            end else begin
               hi_in = mid;
            end
         end
         DP_READ_LO: begin
            mem_re  = 1'b1;
            rd_slot = lo_ff;
         end
         DP_GRAB: begin
            removed_in = pay_rd_ff;
            idx_in     = lo_ff;
            if (dp_status.dn_needed) begin
               mem_re  = 1'b1;
               rd_slot = lo_ff + 1'b1;
            end
         end
         DP_UP_PRIME: begin
            idx_in  = fill_cur_ff;
            mem_re  = 1'b1;
            rd_slot = fill_cur_ff - 1'b1;
         end
         DP_UP_STEP: begin
            // read data holds slot idx-1; next read one further down
            mem_we  = 1'b1;
            wr_slot = idx_ff;
            idx_in  = idx_ff - 1'b1;
            if (dp_status.up_more) begin
               mem_re  = 1'b1;
               rd_slot = idx_ff - SLOT_W'(2);
            end
         end
         DP_DN_STEP: begin
            // read data holds slot idx+1
            mem_we  = 1'b1;
            wr_slot = idx_ff;
            idx_in  = idx_ff + 1'b1;
            if (dp_status.dn_more) begin
               mem_re  = 1'b1;
               rd_slot = idx_ff + SLOT_W'(2);
            end
         end
         DP_INSERT: begin
            mem_we         = 1'b1;
            wr_slot        = lo_ff;
            mem_wkey       = key_ff;
            mem_wpay       = pay_ff;
            fill_wr        = 1'b1;
            fill_wval      = fill_cur_ff + 1'b1;
            rsp_valid_in   = 1'b1;
            rsp_status_in  = STATUS_DONE;
            rsp_bank_in    = BANK_FIELD_W'(bank_ff);
            rsp_pos_in     = POSITION_W'(lo_ff);
            rsp_removed_in = '0;
         end
         DP_REMOVE: begin
            fill_wr        = 1'b1;
            fill_wval      = fill_cur_ff - 1'b1;
            rsp_valid_in   = 1'b1;
            rsp_status_in  = STATUS_DONE;
            rsp_bank_in    = BANK_FIELD_W'(bank_ff);
            rsp_pos_in     = POSITION_W'(lo_ff);
            rsp_removed_in = removed_ff;
         end
         DP_FULL: begin
            rsp_valid_in   = 1'b1;
            rsp_status_in  = STATUS_FULL;
            rsp_bank_in    = '0;
            rsp_pos_in     = '0;
            rsp_removed_in = '0;
         end
         DP_MISSING: begin
            rsp_valid_in   = 1'b1;
            rsp_status_in  = STATUS_MISSING;
            rsp_bank_in    = '0;
            rsp_pos_in     = '0;
            rsp_removed_in = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         key_mem[mem_wa] <= mem_wkey;
         pay_mem[mem_wa] <= mem_wpay;
      end
      if (mem_re) begin
         key_rd_ff <= key_mem[mem_ra];
         pay_rd_ff <= pay_mem[mem_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         for (int b = 0; b < BANK_COUNT; b++) begin
            bank_fill_ff[b] <= '0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (fill_wr) begin
            bank_fill_ff[bank_ff] <= fill_wval;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      key_ff         <= key_in;
      pay_ff         <= pay_in;
      bank_ff        <= bank_in;
      lo_ff          <= lo_in;
      hi_ff          <= hi_in;
      idx_ff         <= idx_in;
      fill_cur_ff    <= fill_cur_in;
      removed_ff     <= removed_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_bank_ff    <= rsp_bank_in;
      rsp_pos_ff     <= rsp_pos_in;
      rsp_removed_ff <= rsp_removed_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {PAD_W'(0), rsp_removed_ff, rsp_pos_ff, rsp_bank_ff};

   a_insert_has_room: assert property (@(posedge clock) disable iff (reset)
      dp_op == DP_INSERT |-> fill_cur_ff < CAP_SLOT)
      else $error("insert into a full bank");

   a_remove_in_range: assert property (@(posedge clock) disable iff (reset)
      dp_op == DP_REMOVE |-> fill_cur_ff != '0 && lo_ff < fill_cur_ff)
      else $error("remove outside the filled slots");

   a_result_slot_free: assert property (@(posedge clock) disable iff (reset)
      (dp_op == DP_INSERT || dp_op == DP_REMOVE || dp_op == DP_FULL
       || dp_op == DP_MISSING) |-> !rsp_valid_ff || rsp_tready)
      else $error("result overwrites a word not yet taken");

   a_up_shift_bound: assert property (@(posedge clock) disable iff (reset)
      dp_op == DP_UP_STEP |-> idx_ff > lo_ff)
      else $error("upward shift passed the insertion slot");

endmodule

`default_nettype wire

// File: hw/rtl/bskt_ctrl.sv
// Controller: sequences search, shift and result steps for one request.
// Depends on bskt_pkg; issues one datapath operation per cycle.
`default_nettype none

module bskt_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  bskt_pkg::dp_status_type dp_status,
   output bskt_pkg::dp_op_type     dp_op
);
   import bskt_pkg::*;

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      dp_op      = DP_NOP;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            // no word is taken while reset is high
            req_tready = !reset;
            if (req_tvalid && !reset) begin
               dp_op    = DP_LOAD;
               state_in = (dp_status.req_insert && dp_status.none_free) ? ST_FULL : ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            priority if (dp_status.search_open) begin
               dp_op    = DP_READ_MID;
               state_in = ST_NARROW;
            end else if (dp_status.item_insert) begin
               if (dp_status.up_needed) begin
                  dp_op    = DP_UP_PRIME;
                  state_in = ST_UP;
               end else begin
                  state_in = ST_INSERT;
               end
            end else if (dp_status.lo_in_range) begin
               dp_op    = DP_READ_LO;
               state_in = ST_CHECK;
            end else if (dp_status.last_bank) begin
               state_in = ST_MISSING;
            end else begin
               dp_op    = DP_NEXT_BANK;
               state_in = ST_SEARCH;
            end
         end
         ST_NARROW: begin
            dp_op    = DP_NARROW;
            state_in = ST_SEARCH;
         end
         ST_CHECK: begin
            priority if (dp_status.key_match) begin
               dp_op    = DP_GRAB;
               state_in = dp_status.dn_needed ? ST_DN : ST_REMOVE;
            end else if (dp_status.last_bank) begin
               state_in = ST_MISSING;
            end else begin
               dp_op    = DP_NEXT_BANK;
               state_in = ST_SEARCH;
            end
         end
         ST_UP: begin
            dp_op    = DP_UP_STEP;
            state_in = dp_status.up_more ? ST_UP : ST_INSERT;
         end
         ST_DN: begin
            dp_op    = DP_DN_STEP;
            state_in = dp_status.dn_more ? ST_DN : ST_REMOVE;
         end
         ST_INSERT: begin
            if (dp_status.out_free) begin
               dp_op    = DP_INSERT;
               state_in = ST_IDLE;
            end
         end
         ST_REMOVE: begin
            if (dp_status.out_free) begin
               dp_op    = DP_REMOVE;
               state_in = ST_IDLE;
            end
         end
         ST_FULL: begin
            if (dp_status.out_free) begin
               dp_op    = DP_FULL;
               state_in = ST_IDLE;
            end
         end
         ST_MISSING: begin
            if (dp_status.out_free) begin
               dp_op    = DP_MISSING;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// File: hw/rtl/banked_sorted_key_table.sv
// Banked sorted key table: insert and delete of key/payload words kept in
// ascending key order per bank. Depends on bskt_pkg, bskt_ctrl, bskt_datapath.
//
// Usage
//   req channel: one word per request. req_tuser selects insert (0) or
//   delete (1); req_tdata carries key and payload. rsp channel: exactly one
//   word per request, in request order, carrying status in rsp_tuser and
//   bank, slot position and removed payload in rsp_tdata.
//   Inserts go to the least-filled bank with room (lowest bank on a tie),
//   before any equal key. Deletes scan banks in order and remove the first
//   equal key of the first bank that holds it.
// Sequencing
//   One request in flight. Each binary search step is a registered read
//   of the table memory, then a compare; each shifted entry takes its own
//   shift step. A delete adds a search per bank tried.
// Reset and stall
//   Reset empties every bank at once (fill counts cleared); the memories
//   need no clearing pass. req_tready stays low while reset is high.
//   A stalled rsp_tready holds the result word in
//   the output register; the next request is still taken and worked on,
//   and waits only at its own result step until the register is free.
`default_nettype none

module banked_sorted_key_table #(
   parameter int BANK_CAPACITY = bskt_pkg::BANK_CAPACITY_DEFAULT,
   parameter int BANK_COUNT    = bskt_pkg::BANK_COUNT_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [bskt_pkg::REQ_TDATA_W-1:0] req_tdata,  // key[31:0], payload[63:32]
   input  logic                             req_tuser,  // operation
   // result channel
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [bskt_pkg::RSP_TDATA_W-1:0] rsp_tdata,  // bank[0], position[6:1],
                                                        // removed_payload[38:7], zero pad
   output logic [bskt_pkg::STATUS_W-1:0]    rsp_tuser   // status
);
   import bskt_pkg::*;

   dp_op_type     dp_op;
   dp_status_type dp_status;

   // sequencer: one datapath operation a cycle
   bskt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .dp_status  (dp_status),
      .dp_op      (dp_op)
   );

   // table memories, fill counts and the result register
   bskt_datapath #(
      .BANK_CAPACITY (BANK_CAPACITY),
      .BANK_COUNT    (BANK_COUNT)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .dp_op      (dp_op),
      .dp_status  (dp_status),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for banked_sorted_key_table: random and directed inserts and deletes,
// with each result word checked against a sorted-bank predictor. Depends on bskt_pkg and the RTL.

module tb;
   import bskt_pkg::*;

   localparam int CAP          = BANK_CAPACITY_DEFAULT;
   localparam int BANKS        = BANK_COUNT_DEFAULT;
   localparam int RANDOM_WORDS = 1030;
   localparam int HOLD_CYCLES  = 400;     // long receiver hold-off, fills the block
   localparam int DRAIN_CYCLES = 300;     // above the worst two-bank delete
   localparam int LIMIT_CYCLES = 2000000;
   localparam int POS_LSB      = BANK_FIELD_W;
   localparam int PAY_LSB      = BANK_FIELD_W + POSITION_W;

   // one expected result word
   typedef struct packed {
      status_type              status;
      logic                    bank;
      logic [POSITION_W-1:0]   position;
      logic [PAYLOAD_W-1:0]    removed;
   } outcome_t;

   // traffic shapes: fill to full, churn near full, drain to empty, mixed
   typedef enum logic [1:0] {
      MODE_FILL,
      MODE_CHURN,
      MODE_DRAIN,
      MODE_MIXED
   } traffic_mode_t;

   // Mirror of the banks plus the queue of results still owed by the block.
   class key_table_scoreboard;
      logic [KEY_W-1:0]     slot_key [BANKS][CAP];
      logic [PAYLOAD_W-1:0] slot_pay [BANKS][CAP];
      int                   fill [BANKS];
      outcome_t             awaited [$];
      int unsigned          errors;
      int unsigned          checked;

      function new();
         foreach (fill[b]) fill[b] = 0;
         errors  = 0;
         checked = 0;
      endfunction

      // first slot whose key is not below k
      function int lower_slot(int b, logic [KEY_W-1:0] k);
         int lo, hi, mid;
         lo = 0;
         hi = fill[b];
         while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (slot_key[b][mid] < k) lo = mid + 1;
            else hi = mid;
         end
         return lo;
      endfunction

      function int total_fill();
         int n;
         n = 0;
         foreach (fill[b]) n += fill[b];
         return n;
      endfunction

      // apply an accepted request to the mirror and queue its result
      function void note_request(logic op, logic [KEY_W-1:0] key, logic [PAYLOAD_W-1:0] pay);
         outcome_t o;
         int       b, best, pos, i;
         bit       found;
         o        = '0;
         o.status = STATUS_DONE;
         if (op == OP_INSERT) begin
            found = 0;
            best  = 0;
            for (b = 0; b < BANKS; b++) begin
               if (fill[b] < CAP && (!found || fill[b] < fill[best])) begin
                  best  = b;
                  found = 1;
               end
            end
            if (!found) begin
               o.status = STATUS_FULL;
            end else begin
               pos = lower_slot(best, key);
               for (i = fill[best]; i > pos; i--) begin
                  slot_key[best][i] = slot_key[best][i-1];
                  slot_pay[best][i] = slot_pay[best][i-1];
               end
               slot_key[best][pos] = key;
               slot_pay[best][pos] = pay;
               fill[best]++;
               o.bank     = best[0];
               o.position = pos[POSITION_W-1:0];
            end
         end else begin
            o.status = STATUS_MISSING;
            for (b = 0; b < BANKS && o.status == STATUS_MISSING; b++) begin
               pos = lower_slot(b, key);
               if (pos < fill[b] && slot_key[b][pos] == key) begin
                  o.status   = STATUS_DONE;
                  o.bank     = b[0];
                  o.position = pos[POSITION_W-1:0];
                  o.removed  = slot_pay[b][pos];
                  for (i = pos; i + 1 < fill[b]; i++) begin
                     slot_key[b][i] = slot_key[b][i+1];
                     slot_pay[b][i] = slot_pay[b][i+1];
                  end
                  fill[b]--;
               end
            end
         end
         awaited.push_back(o);
      endfunction

      task report(string what, logic [31:0] got, logic [31:0] want);
         $display("MISMATCH word %0d %s: got 0x%0h, wanted 0x%0h", checked, what, got, want);
         errors++;
      endtask

      task check_result(logic [STATUS_W-1:0] status, logic bank,
                        logic [POSITION_W-1:0] position, logic [PAYLOAD_W-1:0] removed);
         outcome_t o;
         checked++;
         if (awaited.size() == 0) begin
            report("unrequested, status", status, 0);
            return;
         end
         o = awaited.pop_front();
         if (status !== o.status)     report("status", status, o.status);
         if (bank !== o.bank)         report("bank", bank, o.bank);
         if (position !== o.position) report("position", position, o.position);
         if (removed !== o.removed)   report("removed payload", removed, o.removed);
      endtask
   endclass

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;   // key[31:0], payload[63:32]
   logic                   req_tuser;   // operation
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;   // bank[0], position[6:1], removed_payload[38:7], pad
   logic [STATUS_W-1:0]    rsp_tuser;   // status

   key_table_scoreboard sb;
   int  cycles          = 0;
   bit  hold_pending    = 0;   // main flow asks the receiver for one long hold-off
   bit  sender_steady   = 0;   // stretches with no sender gaps
   bit  receiver_steady = 0;   // stretches with no receiver stalls

   banked_sorted_key_table #(
      .BANK_CAPACITY(CAP),
      .BANK_COUNT   (BANKS)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // hang guard
   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // gap or stall length: mostly none, some short, a few long
   function automatic int idle_len(bit steady);
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // a key currently held in some bank; caller makes sure one exists
   function automatic logic [KEY_W-1:0] stored_key();
      int b;
      do b = $urandom_range(0, BANKS - 1); while (sb.fill[b] == 0);
      return sb.slot_key[b][$urandom_range(0, sb.fill[b] - 1)];
   endfunction

   // small pool for duplicates, the extremes, copies of held keys, full range
   function automatic logic [KEY_W-1:0] insert_key();
      int r;
      r = $urandom_range(0, 99);
      if (r < 30) return $urandom_range(0, 15);
      if (r < 38) begin
         case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            2:       return 32'h1;
            default: return 32'hFFFF_FFFE;
         endcase
      end
      if (r < 55 && sb.total_fill() > 0) return stored_key();
      return $urandom;
   endfunction

   // mostly hits; the rest likely misses
   function automatic logic [KEY_W-1:0] delete_key();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70 && sb.total_fill() > 0) return stored_key();
      if (r < 85) return $urandom_range(0, 15);
      return $urandom;
   endfunction

   function automatic logic [PAYLOAD_W-1:0] pick_payload();
      int r;
      r = $urandom_range(0, 99);
      if (r < 5) return '0;
      if (r < 10) return '1;
      return $urandom;
   endfunction

   // Offer one word and hold it until taken. tvalid stays high after the
   // handshake, so back-to-back words never drop it within a step.
   task automatic send_word(logic op, logic [KEY_W-1:0] key, logic [PAYLOAD_W-1:0] pay);
      int g;
      g = idle_len(sender_steady);
      repeat (g) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {pay, key};
      do @(posedge clock); while (!req_tready);
      sb.note_request(op, key, pay);
   endtask

   // Random traffic cycling through fill, churn at full, drain and mixed
   // phases, so that full banks, deep shifts and empty deletes all recur.
   task automatic run_traffic();
      traffic_mode_t   mode;
      int              sent, left, ins_pct;
      logic            op;
      logic [KEY_W-1:0] key;
      mode = MODE_FILL;
      left = 0;
      sent = 0;
      while (sent < RANDOM_WORDS) begin
         if (sent % 100 == 0) sender_steady = ($urandom_range(0, 2) == 0);
         case (mode)
            MODE_FILL:  ins_pct = 90;
            MODE_CHURN: ins_pct = 60;
            MODE_DRAIN: ins_pct = 12;
            default:    ins_pct = 55;
         endcase
         op  = ($urandom_range(0, 99) < ins_pct) ? OP_INSERT : OP_DELETE;
         key = (op == OP_INSERT) ? insert_key() : delete_key();
         send_word(op, key, pick_payload());
         sent++;
         case (mode)
            MODE_FILL: begin
               if (sb.total_fill() == BANKS * CAP) begin
                  mode = MODE_CHURN;
                  left = 80;
               end
            end
            MODE_CHURN: begin
               left--;
               if (left == 0) mode = MODE_DRAIN;
            end
            MODE_DRAIN: begin
               if (sb.total_fill() == 0) begin
                  mode = MODE_MIXED;
                  left = 150;
               end
            end
            default: begin
               left--;
               if (left == 0) mode = MODE_FILL;
            end
         endcase
      end
   endtask

   // Result side: random stalls, steady stretches, and one long hold-off
   // on request, counted here so the sender keeps pushing meanwhile.
   initial begin
      int g, turns;
      rsp_tready = 1'b0;
      turns      = 0;
      forever begin
         @(negedge clock);
         turns++;
         if (turns % 150 == 0) receiver_steady = ($urandom_range(0, 2) == 0);
         if (hold_pending) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_pending = 0;
            rsp_tready <= 1'b1;
         end else begin
            g = idle_len(receiver_steady);
            if (g == 0) begin
               rsp_tready <= 1'b1;
            end else begin
               rsp_tready <= 1'b0;
               repeat (g) @(negedge clock);
               rsp_tready <= 1'b1;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result(rsp_tuser, rsp_tdata[0], rsp_tdata[PAY_LSB-1:POS_LSB],
                         rsp_tdata[PAY_LSB+PAYLOAD_W-1:PAY_LSB]);
   end

   initial begin
      sb         = new();
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tuser  = OP_INSERT;
      req_tdata  = '0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // directed: empty delete, extremes, duplicates on both sides, misses
      send_word(OP_DELETE, 32'd5, 32'h0);               // nothing held yet
      send_word(OP_INSERT, 32'h0, 32'hFFFF_FFFF);       // lowest key, bank 0
      send_word(OP_INSERT, 32'hFFFF_FFFF, 32'h0);       // highest key, bank 1
      send_word(OP_INSERT, 32'd100, 32'd1);             // tie on fill: bank 0
      send_word(OP_INSERT, 32'd100, 32'd2);             // lands before the top key
      send_word(OP_INSERT, 32'd100, 32'd3);             // duplicate goes first
      send_word(OP_INSERT, 32'd50, 32'd4);
      send_word(OP_DELETE, 32'd100, 32'h0);             // removes the lowest duplicate
      send_word(OP_DELETE, 32'd100, 32'h0);
      send_word(OP_DELETE, 32'd100, 32'h0);             // now from bank 1
      send_word(OP_DELETE, 32'd100, 32'h0);             // gone everywhere
      send_word(OP_DELETE, 32'hFFFF_FFFF, 32'h0);
      send_word(OP_DELETE, 32'h0, 32'h0);
      send_word(OP_DELETE, 32'h0, 32'h0);
      send_word(OP_INSERT, 32'h8000_0000, 32'h5555_5555);
      send_word(OP_INSERT, 32'h7FFF_FFFF, 32'hAAAA_AAAA);
      send_word(OP_DELETE, 32'h7FFF_FFFF, 32'h0);
      send_word(OP_DELETE, 32'h8000_0000, 32'h0);
      send_word(OP_DELETE, 32'd50, 32'h0);

      hold_pending = 1;
      run_traffic();
      @(negedge clock);
      req_tvalid <= 1'b0;

      while (sb.awaited.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule

// File: sim.f
hw/rtl/bskt_pkg.sv
hw/rtl/bskt_datapath.sv
hw/rtl/bskt_ctrl.sv
hw/rtl/banked_sorted_key_table.sv
tb/sv/tb.sv
